### rtl/core/sidstep_pkg.sv
// Shared types, register indexes and phase tables for the sidereal stepper sequencer.
package sidstep_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_RUN_MODE       = 3'd0,
		REG_HALF_STEP_MODE = 3'd1,
		REG_BASE_INTERVAL  = 3'd2,
		REG_EXTRA_TICK     = 3'd3,
		REG_POWER_DOWN     = 3'd4,
		REG_POWER_UP_LEAD  = 3'd5,
		REG_REWIND_PERIOD  = 3'd6,
		REG_COIL_MASK      = 3'd7
	} reg_index_t;

	// reset values of the configuration registers
	localparam logic        RST_RUN_MODE       = 1'b0;
	localparam logic        RST_HALF_STEP_MODE = 1'b1;
	localparam logic [15:0] RST_BASE_INTERVAL  = 16'd9138;
	localparam logic [6:0]  RST_EXTRA_TICK     = 7'd2;
	localparam logic [15:0] RST_POWER_DOWN     = 16'd1000;
	localparam logic [15:0] RST_POWER_UP_LEAD  = 16'd1000;
	localparam logic [7:0]  RST_REWIND_PERIOD  = 8'd200;
	localparam logic [3:0]  RST_COIL_MASK      = 4'hF;

	localparam int CFG_DATA_W = 16;

	typedef struct packed {
		logic        run_mode;
		logic        half_step_mode;
		logic [15:0] base_interval;
		logic [6:0]  extra_tick_mask;
		logic [15:0] power_down_tick;
		logic [15:0] power_up_lead;
		logic [7:0]  rewind_period;
		logic [3:0]  coil_enable_mask;
	} cfg_t;

	typedef struct packed {
		logic [3:0] coil_bits;
		logic       step_taken;
		logic [2:0] pattern_slot;
	} result_t;

	// eight-phase half-step table
	function automatic logic [3:0] half_phase(input logic [2:0] pos);
		logic [3:0] pat;
		case (pos)
			3'd0:    pat = 4'd1;
			3'd1:    pat = 4'd9;
			3'd2:    pat = 4'd8;
			3'd3:    pat = 4'd10;
			3'd4:    pat = 4'd2;
			3'd5:    pat = 4'd6;
			3'd6:    pat = 4'd4;
			default: pat = 4'd5;
		endcase
		return pat;
	endfunction

	// four-phase full-step table
	function automatic logic [3:0] full_phase(input logic [1:0] pos);
		logic [3:0] pat;
		case (pos)
			2'd0:    pat = 4'd1;
			2'd1:    pat = 4'd8;
			2'd2:    pat = 4'd2;
			default: pat = 4'd4;
		endcase
		return pat;
	endfunction

endpackage

### rtl/core/sidstep_core.sv
// Tick counters, phase state and coil drive update for one tick request.
module sidstep_core #(
	parameter int PATTERN_LEN = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sidstep_pkg::cfg_t    cfg,
	input  logic                 fire,
	input  logic                 tick_enable,
	output sidstep_pkg::result_t result
);
	import sidstep_pkg::*;

	localparam logic [3:0] LEN_W = 4'(PATTERN_LEN);

	logic [15:0] track_cnt_q, track_cnt_d;
	logic [2:0]  pat_idx_q, pat_idx_d;
	logic [2:0]  phase_q, phase_d;
	logic [3:0]  last_coils_q, last_coils_d;
	logic [3:0]  coil_q, coil_d;
	logic [7:0]  rew_cnt_q, rew_cnt_d;
	logic        stepped;

	logic [3:0]  step_pat;
	logic [16:0] interval_sum;
	logic [15:0] interval;
	logic [15:0] track_inc;
	logic [16:0] lead_sum;
	logic [7:0]  rew_inc;
	logic [7:0]  extra_bits;
	logic [3:0]  idx_inc;

	// phase pattern for a step from the current position
	always_comb begin
		step_pat = (cfg.half_step_mode ? half_phase(phase_q) : full_phase(phase_q[1:0]))
			& cfg.coil_enable_mask;
	end

	// slot interval, saturated at the counter range
	assign extra_bits   = {1'b0, cfg.extra_tick_mask};
	assign interval_sum = {1'b0, cfg.base_interval} + {16'd0, extra_bits[pat_idx_q]};
	assign interval     = interval_sum[16] ? 16'hFFFF : interval_sum[15:0];
	assign track_inc    = track_cnt_q + 16'd1;
	assign lead_sum     = {1'b0, track_inc} + {1'b0, cfg.power_up_lead};
	assign rew_inc      = rew_cnt_q + 8'd1;
	assign idx_inc      = {1'b0, pat_idx_q} + 4'd1;

	// next state for one tick
	always_comb begin
		track_cnt_d  = track_cnt_q;
		pat_idx_d    = pat_idx_q;
		phase_d      = phase_q;
		last_coils_d = last_coils_q;
		coil_d       = coil_q;
		rew_cnt_d    = rew_cnt_q;
		stepped      = 1'b0;
		if (tick_enable) begin
			if (cfg.run_mode) begin
				rew_cnt_d = rew_inc;
				if (rew_inc == cfg.rewind_period) begin
					coil_d    = step_pat;
					phase_d   = phase_q + 3'd1;
					rew_cnt_d = 8'd0;
					stepped   = 1'b1;
				end
			end else begin
				track_cnt_d = track_inc;
				if (track_inc == cfg.power_down_tick) begin
					coil_d = 4'd0;
				end else if (lead_sum == {1'b0, interval}) begin
					coil_d = last_coils_q & cfg.coil_enable_mask;
				end else if (track_inc == interval) begin
					coil_d       = step_pat;
					last_coils_d = step_pat;
					phase_d      = phase_q - 3'd1;
					pat_idx_d    = (idx_inc >= LEN_W) ? 3'd0 : idx_inc[2:0];
					track_cnt_d  = 16'd0;
					stepped      = 1'b1;
				end
			end
		end
	end

	// advance state on an accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_cnt_q  <= '0;
			pat_idx_q    <= '0;
			phase_q      <= '0;
			last_coils_q <= '0;
			coil_q       <= '0;
			rew_cnt_q    <= '0;
		end else if (fire) begin
			track_cnt_q  <= track_cnt_d;
			pat_idx_q    <= pat_idx_d;
			phase_q      <= phase_d;
			last_coils_q <= last_coils_d;
			coil_q       <= coil_d;
			rew_cnt_q    <= rew_cnt_d;
		end
	end

	// result of this request, taken from the updated state
	always_comb begin
		result.coil_bits    = coil_d;
		result.step_taken   = stepped;
		result.pattern_slot = pat_idx_d;
	end

endmodule

### rtl/core/sidstep_outbuf.sv
// Two-entry result buffer between the sequencer and the output channel.
module sidstep_outbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sidstep_pkg::result_t push_data,
	output logic                 has_room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sidstep_pkg::result_t out_data
);
	import sidstep_pkg::*;

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign has_room  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = entry_q[rd_ptr_q];

	// store the incoming result
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### rtl/core/sidereal_stepper_sequencer_top.sv
// Top level of the sidereal stepper sequencer: configuration registers and channels.
//
// Each input request carries tick_enable: 1 means one 10 us timer tick has
// elapsed, 0 leaves all state untouched. Every request yields exactly one
// result: the coil drive bits, a flag telling whether this tick moved the
// motor phase, and the interval pattern slot now being timed.
// A request is processed in the cycle it is accepted; its result queues for
// output behind unread results. A new request can be accepted every cycle
// unless the buffer is full. The tick update (counter increment, interval
// compare, phase table lookup) is one pass of logic into the state registers.
// A two-entry result buffer decouples the channels: input keeps flowing while
// one result waits, and in_ready drops only when two results are unread.
// Configuration registers are written through cfg_we/cfg_index/cfg_data at
// any clock edge with cfg_we high; write them only while the block is idle.
// Reset clears counters, phase and coil drive (coils off), empties the result
// buffer and loads the default tracking configuration.
module sidereal_stepper_sequencer_top #(
	parameter int PATTERN_LEN = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        tick_enable,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  coil_bits,
	output logic        step_taken,
	output logic [2:0]  pattern_slot,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import sidstep_pkg::*;

	cfg_t    cfg_q;
	result_t core_res;
	result_t out_res;
	logic    fire;
	logic    has_room;

	assign in_ready = has_room;
	assign fire     = in_valid && has_room;

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_mode         <= RST_RUN_MODE;
			cfg_q.half_step_mode   <= RST_HALF_STEP_MODE;
			cfg_q.base_interval    <= RST_BASE_INTERVAL;
			cfg_q.extra_tick_mask  <= RST_EXTRA_TICK;
			cfg_q.power_down_tick  <= RST_POWER_DOWN;
			cfg_q.power_up_lead    <= RST_POWER_UP_LEAD;
			cfg_q.rewind_period    <= RST_REWIND_PERIOD;
			cfg_q.coil_enable_mask <= RST_COIL_MASK;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_RUN_MODE:       cfg_q.run_mode         <= cfg_data[0];
				REG_HALF_STEP_MODE: cfg_q.half_step_mode   <= cfg_data[0];
				REG_BASE_INTERVAL:  cfg_q.base_interval    <= cfg_data;
				REG_EXTRA_TICK:     cfg_q.extra_tick_mask  <= cfg_data[6:0];
				REG_POWER_DOWN:     cfg_q.power_down_tick  <= cfg_data;
				REG_POWER_UP_LEAD:  cfg_q.power_up_lead    <= cfg_data;
				REG_REWIND_PERIOD:  cfg_q.rewind_period    <= cfg_data[7:0];
				REG_COIL_MASK:      cfg_q.coil_enable_mask <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	sidstep_core #(
		.PATTERN_LEN (PATTERN_LEN)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.fire        (fire),
		.tick_enable (tick_enable),
		.result      (core_res)
	);

	sidstep_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_data (core_res),
		.has_room  (has_room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_res)
	);

	// drive the result ports
	assign coil_bits    = out_res.coil_bits;
	assign step_taken   = out_res.step_taken;
	assign pattern_slot = out_res.pattern_slot;

endmodule

### test/sidereal_stepper_sequencer_top_tb.sv
// Self-checking testbench for the sidereal stepper sequencer: tracking, rewind and flow control.
module sidereal_stepper_sequencer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sidstep_pkg::*;

	localparam int SLOT_COUNT = 7;
	// phase tables, entry i in bits [4i+3:4i]
	localparam logic [31:0] HALF_SEQ = {4'd5, 4'd4, 4'd6, 4'd2, 4'd10, 4'd8, 4'd9, 4'd1};
	localparam logic [15:0] FULL_SEQ = {4'd4, 4'd2, 4'd8, 4'd1};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        tick_enable = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  coil_bits;
	logic        step_taken;
	logic [2:0]  pattern_slot;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_RUN_MODE;
	logic [15:0] cfg_data = 16'd0;

	// motor state as the block should hold it
	cfg_t        mcfg;
	logic [15:0] trk_count;
	logic [2:0]  slot_idx;
	logic [2:0]  phase_pos;
	logic [3:0]  last_coils;
	logic [3:0]  coil_level;
	logic [7:0]  rw_count;

	result_t motor_results_q[$];

	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int hold_off_cycles = 0;
	int mismatches = 0;
	int results_seen = 0;
	int requests_sent = 0;
	int random_requests = 0;
	int track_steps = 0;
	int rewind_steps = 0;
	int settings_applied = 0;

	sidereal_stepper_sequencer_top #(
		.PATTERN_LEN(SLOT_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.tick_enable(tick_enable),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.coil_bits(coil_bits),
		.step_taken(step_taken),
		.pattern_slot(pattern_slot),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// run-away guard, several times the slowest legal run
	initial begin
		#8_000_000;
		$display("sidereal_stepper_sequencer_top_tb: done, errors");
		$finish;
	end

	function automatic void reset_motor();
		mcfg.run_mode = RST_RUN_MODE;
		mcfg.half_step_mode = RST_HALF_STEP_MODE;
		mcfg.base_interval = RST_BASE_INTERVAL;
		mcfg.extra_tick_mask = RST_EXTRA_TICK;
		mcfg.power_down_tick = RST_POWER_DOWN;
		mcfg.power_up_lead = RST_POWER_UP_LEAD;
		mcfg.rewind_period = RST_REWIND_PERIOD;
		mcfg.coil_enable_mask = RST_COIL_MASK;
		trk_count = '0;
		slot_idx = '0;
		phase_pos = '0;
		last_coils = '0;
		coil_level = '0;
		rw_count = '0;
	endfunction

	// table entry at the current phase, masked for the enabled coils
	function automatic logic [3:0] phase_coils();
		logic [3:0] pat;
		if (mcfg.half_step_mode) begin
			pat = HALF_SEQ[phase_pos*4 +: 4];
		end else begin
			pat = FULL_SEQ[phase_pos[1:0]*4 +: 4];
		end
		return pat & mcfg.coil_enable_mask;
	endfunction

	// advance the motor state by one request and give the expected result
	function automatic result_t advance_motor(input logic tick);
		result_t r;
		int ivl;
		logic moved;
		moved = 1'b0;
		if (tick) begin
			if (mcfg.run_mode) begin
				rw_count = rw_count + 8'd1;
				if (rw_count == mcfg.rewind_period) begin
					coil_level = phase_coils();
					phase_pos = phase_pos + 3'd1;
					rw_count = '0;
					moved = 1'b1;
				end
			end else begin
				ivl = int'(mcfg.base_interval) + int'(mcfg.extra_tick_mask[slot_idx]);
				if (ivl > 65535) ivl = 65535;
				trk_count = trk_count + 16'd1;
				if (trk_count == mcfg.power_down_tick) begin
					coil_level = '0;
				end else if (int'(trk_count) + int'(mcfg.power_up_lead) == ivl) begin
					coil_level = last_coils & mcfg.coil_enable_mask;
				end else if (int'(trk_count) == ivl) begin
					coil_level = phase_coils();
					last_coils = coil_level;
					phase_pos = phase_pos - 3'd1;
					slot_idx = (slot_idx == SLOT_COUNT - 1) ? 3'd0 : slot_idx + 3'd1;
					trk_count = '0;
					moved = 1'b1;
				end
			end
		end
		r.coil_bits = coil_level;
		r.step_taken = moved;
		r.pattern_slot = slot_idx;
		return r;
	endfunction

	// smallest safe base interval: keep the counter below it
	function automatic logic [15:0] base_above(input int want);
		return (want > int'(trk_count)) ? 16'(want) : trk_count + 16'd1;
	endfunction

	// fill unused upper data bits with junk when asked
	function automatic logic [15:0] with_noise(input logic [15:0] v, input int width,
			input bit noisy);
		if (noisy && width < 16) begin
			return v | (16'($urandom) & ~((16'd1 << width) - 16'd1));
		end
		return v;
	endfunction

	task automatic write_reg(input reg_index_t idx, input logic [15:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
	endtask

	// drain the block, then load every register
	task automatic apply_config(input cfg_t c, input bit noisy);
		in_valid <= 1'b0;
		while (motor_results_q.size() != 0) @(posedge clk);
		write_reg(REG_RUN_MODE, with_noise(16'(c.run_mode), 1, noisy));
		write_reg(REG_HALF_STEP_MODE, with_noise(16'(c.half_step_mode), 1, noisy));
		write_reg(REG_BASE_INTERVAL, c.base_interval);
		write_reg(REG_EXTRA_TICK, with_noise(16'(c.extra_tick_mask), 7, noisy));
		write_reg(REG_POWER_DOWN, c.power_down_tick);
		write_reg(REG_POWER_UP_LEAD, c.power_up_lead);
		write_reg(REG_REWIND_PERIOD, with_noise(16'(c.rewind_period), 8, noisy));
		write_reg(REG_COIL_MASK, with_noise(16'(c.coil_enable_mask), 4, noisy));
		cfg_we <= 1'b0;
		@(posedge clk);
		mcfg = c;
		settings_applied++;
	endtask

	// offer one request, hold it until accepted, then predict its result
	task automatic send_tick(input logic en);
		result_t want;
		while (!tx_steady && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		tick_enable <= en;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		want = advance_motor(en);
		motor_results_q.push_back(want);
		requests_sent++;
		if (want.step_taken) begin
			if (mcfg.run_mode) rewind_steps++;
			else track_steps++;
		end
	endtask

	// receiver: random stalls, steady stretches, and a counted hold-off
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				out_ready <= 1'b0;
				hold_off_cycles--;
			end else if (rx_steady) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 38);
			end
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (motor_results_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: unexpected result coils=%h step=%0d slot=%0d", $realtime,
						coil_bits, step_taken, pattern_slot);
				end
			end else begin
				want = motor_results_q.pop_front();
				if (coil_bits !== want.coil_bits || step_taken !== want.step_taken ||
						pattern_slot !== want.pattern_slot) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result %0d: expected coils=%h step=%0d slot=%0d, got coils=%h step=%0d slot=%0d",
							$realtime, results_seen, want.coil_bits, want.step_taken,
							want.pattern_slot, coil_bits, step_taken, pattern_slot);
					end
				end
			end
		end
	end

	// default settings: coils stay off, idle requests hold everything
	task automatic test_reset_state();
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
	endtask

	// short intervals, half-step table, extra ticks on some slots
	task automatic test_half_step_tracking();
		cfg_t c;
		int i;
		c = mcfg;
		c.run_mode = 1'b0;
		c.half_step_mode = 1'b1;
		c.base_interval = base_above(3);
		c.extra_tick_mask = 7'b0000101;
		c.power_down_tick = 16'hFFFF;
		c.power_up_lead = 16'd1;
		c.coil_enable_mask = 4'hF;
		apply_config(c, 1'b0);
		for (i = 0; i < 12; i++) send_tick(i % 5 != 4);
	endtask

	// full-step table, power-down right after the step, partial coil mask
	task automatic test_full_step_tracking();
		cfg_t c;
		int i;
		c = mcfg;
		c.half_step_mode = 1'b0;
		c.base_interval = base_above(2);
		c.extra_tick_mask = 7'b1010010;
		c.power_down_tick = 16'd1;
		c.power_up_lead = 16'd1;
		c.coil_enable_mask = 4'b1010;
		apply_config(c, 1'b0);
		for (i = 0; i < 8; i++) send_tick(1'b1);
	endtask

	// zero lead and power-down on the interval both block the step;
	// then a counter left past its interval counts on until a larger one catches it
	task automatic test_blocked_steps();
		cfg_t c;
		int stop_at;
		c = mcfg;
		c.half_step_mode = 1'b1;
		c.base_interval = base_above(4);
		c.extra_tick_mask = 7'd0;
		c.power_down_tick = 16'hFFFF;
		c.power_up_lead = 16'd0;
		c.coil_enable_mask = 4'hF;
		apply_config(c, 1'b0);
		stop_at = int'(c.base_interval) + 1;
		while (int'(trk_count) != stop_at) send_tick(1'b1);

		c.base_interval = trk_count + 16'd3;
		c.power_down_tick = c.base_interval;
		c.power_up_lead = 16'd1;
		apply_config(c, 1'b0);
		stop_at = int'(c.base_interval) + 2;
		while (int'(trk_count) != stop_at) send_tick(1'b1);

		c.base_interval = trk_count + 16'd4;
		c.power_down_tick = 16'hFFFF;
		apply_config(c, 1'b0);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		send_tick(1'b1);
		while (trk_count != 16'd0) send_tick(1'b1);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// largest base plus an extra tick must clamp the interval
	task automatic test_interval_saturation();
		cfg_t c;
		c = mcfg;
		c.base_interval = 16'hFFFF;
		c.extra_tick_mask = 7'h7F;
		c.power_down_tick = 16'd0;
		c.power_up_lead = 16'hFFFE;
		apply_config(c, 1'b0);
		repeat (3) send_tick(1'b1);
	endtask

	// backward stepping at the shortest, longest and wrapping periods
	task automatic test_rewind_periods();
		cfg_t c;
		int i;
		c = mcfg;
		c.run_mode = 1'b1;
		c.half_step_mode = 1'b1;
		c.rewind_period = 8'd1;
		c.coil_enable_mask = 4'hF;
		apply_config(c, 1'b0);
		for (i = 0; i < 10; i++) send_tick(i % 4 != 3);

		c.half_step_mode = 1'b0;
		c.rewind_period = 8'd255;
		c.coil_enable_mask = 4'b0110;
		apply_config(c, 1'b0);
		repeat (260) send_tick(1'b1);

		c.half_step_mode = 1'b1;
		c.rewind_period = 8'd0;
		c.coil_enable_mask = 4'h0;
		apply_config(c, 1'b0);
		repeat (260) send_tick(1'b1);
	endtask

	// hold off the receiver while requests keep coming, so the input stalls
	task automatic test_output_backpressure();
		cfg_t c;
		c = mcfg;
		c.run_mode = 1'b0;
		c.half_step_mode = 1'b1;
		c.base_interval = base_above(3);
		c.extra_tick_mask = 7'($urandom);
		c.power_down_tick = 16'hFFFF;
		c.power_up_lead = 16'd1;
		c.coil_enable_mask = 4'hF;
		apply_config(c, 1'b0);
		tx_steady = 1'b1;
		hold_off_cycles = 300;
		repeat (60) send_tick(1'b1);
		tx_steady = 1'b0;
	endtask

	// random settings, each followed by a burst of mostly live ticks
	task automatic test_random_phases();
		cfg_t c;
		int n;
		int pick;
		while (random_requests < 800) begin
			c = mcfg;
			c.run_mode = ($urandom_range(99) < 30);
			c.half_step_mode = 1'($urandom_range(1));
			pick = $urandom_range(99);
			if (pick < 80) c.base_interval = base_above($urandom_range(2, 20));
			else if (pick < 95) c.base_interval = base_above($urandom_range(21, 300));
			else c.base_interval = 16'hFFFF;
			c.extra_tick_mask = 7'($urandom);
			if ($urandom_range(9) == 0) begin
				c.power_up_lead = 16'($urandom);
			end else begin
				c.power_up_lead = 16'($urandom_range(1, int'(c.base_interval) - 1));
			end
			if ($urandom_range(1)) begin
				c.power_down_tick = 16'($urandom_range(1, int'(c.base_interval) - 1));
			end else begin
				c.power_down_tick = 16'($urandom);
			end
			if ($urandom_range(9) < 7) c.rewind_period = 8'($urandom_range(1, 12));
			else c.rewind_period = 8'($urandom);
			if ($urandom_range(4) == 0) c.coil_enable_mask = 4'hF;
			else c.coil_enable_mask = 4'($urandom);
			apply_config(c, 1'($urandom_range(1)));
			tx_steady = ($urandom_range(7) == 0);
			rx_steady = ($urandom_range(7) == 0);
			n = $urandom_range(30, 80);
			repeat (n) send_tick($urandom_range(99) < 85);
			random_requests += n;
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin : run_tests
		int wait_cycles;
		reset_motor();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_half_step_tracking();
		test_full_step_tracking();
		test_blocked_steps();
		test_interval_saturation();
		test_rewind_periods();
		test_output_backpressure();
		test_random_phases();

		// drain, then let the pipeline settle
		in_valid <= 1'b0;
		wait_cycles = 0;
		while (motor_results_q.size() != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (8) @(posedge clk);
		if (motor_results_q.size() != 0) begin
			mismatches += motor_results_q.size();
			$display("%0d expected results never came out", motor_results_q.size());
		end

		$display("covered %0d requests under %0d register settings, %0d results checked",
			requests_sent, settings_applied, results_seen);
		$display("took %0d tracking and %0d rewind steps, %0d mismatches",
			track_steps, rewind_steps, mismatches);
		if (mismatches == 0) begin
			$display("sidereal_stepper_sequencer_top_tb: done, clean");
		end else begin
			$display("sidereal_stepper_sequencer_top_tb: done, errors");
		end
		$finish;
	end

endmodule

### sidereal_stepper_sequencer_top.f
rtl/core/sidstep_pkg.sv
rtl/core/sidstep_core.sv
rtl/core/sidstep_outbuf.sv
rtl/core/sidereal_stepper_sequencer_top.sv
test/sidereal_stepper_sequencer_top_tb.sv
